/* hdl/buzzer_tone_sweep_melody_player_defines.svh */
// Assertion macros shared by the buzzer player checker.
`ifndef BUZZER_TONE_SWEEP_MELODY_PLAYER_DEFINES_SVH
`define BUZZER_TONE_SWEEP_MELODY_PLAYER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BZT_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("buzzer player check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define BZT_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("buzzer player check failed");

`endif

/* hdl/bzt_pkg.sv */
// Shared constants, codes, types and helper functions of the buzzer player.
package bzt_pkg;

  // Note memory geometry.
  localparam int NOTE_DEPTH = 64;
  localparam int NOTE_AW    = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
  localparam int NOTE_CW    = $clog2(NOTE_DEPTH + 1);

  // Period scale: wrap = scale / frequency.
  localparam int unsigned TICKS_PER_SECOND_SCALE = 1000000;

  localparam logic [15:0] DUR_ENDLESS  = 16'hFFFF;
  localparam logic [15:0] PERIOD_RESET = 16'd400;
  localparam logic [15:0] TONE_RESET   = 16'd1000;

  // Serial divider geometry.
  localparam int DIV_W   = 32;
  localparam int DIV_CW  = $clog2(DIV_W);
  localparam int DSR_W   = 17;

  // Request codes.
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  // Sound modes.
  localparam logic [1:0] MODE_TONE   = 2'd0;
  localparam logic [1:0] MODE_SWEEP  = 2'd1;
  localparam logic [1:0] MODE_MELODY = 2'd2;

  // Quietness codes.
  localparam logic [2:0] SOFT_SHIFT4 = 3'd1;
  localparam logic [2:0] SOFT_SHIFT6 = 3'd2;
  localparam logic [2:0] SOFT_SHIFT7 = 3'd3;
  localparam logic [2:0] SOFT_RING   = 3'd4;
  localparam logic [2:0] SOFT_NONE   = 3'd0;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_TONE     = 3'd1;
  localparam logic [2:0] REG_SW_START = 3'd2;
  localparam logic [2:0] REG_SW_END   = 3'd3;
  localparam logic [2:0] REG_ON       = 3'd4;
  localparam logic [2:0] REG_OFF      = 3'd5;
  localparam logic [2:0] REG_DUR      = 3'd6;
  localparam logic [2:0] REG_COUNT    = 3'd7;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NOP, OP_LATCH, OP_WRITE, OP_START, OP_TICK, OP_CPOS_GO, OP_CPOS_GET,
    OP_TONE_DUTY, OP_SWEEP_SET, OP_MUL, OP_F_START, OP_IDIV_GO, OP_IDIV_GET,
    OP_WRAP_ZERO, OP_WDIV_GO, OP_WDIV_GET, OP_MEL_STOP, OP_NOTE_RD,
    OP_NOTE_SKIP, OP_NOTE_GLIDE, OP_NOTE_PLAY, OP_NEXT_GET
  } op_e;

  typedef struct packed {
    logic [1:0]  sound_mode;
    logic [15:0] tone_frequency;
    logic [15:0] sweep_start_freq;
    logic [15:0] sweep_end_freq;
    logic [15:0] on_time_ms;
    logic [15:0] off_time_ms;
    logic [15:0] total_duration_ms;
    logic [6:0]  note_count;
  } cfg_t;

  typedef struct packed {
    op_e  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic [1:0] mode;
    logic       active;
    logic       start_blocked;
    logic       tick_stop;
    logic       sum_zero;
    logic       c_le_on;
    logic       idx_ge_cnt;
    logic       t_gt_len;
    logic       nf_zero;
    logic       glide_ok;
    logic       span_zero;
    logic       f_zero;
    logic       div_done;
  } sts_t;

  typedef struct packed {
    logic        playing;
    logic        wrap_valid;
    logic [15:0] period_wrap;
    logic [14:0] duty_level;
    logic        stopped_now;
  } res_t;

  // Compare level lowered by a note's quietness.
  function automatic logic [14:0] soft_shift(input logic [14:0] d, input logic [2:0] s);
    logic [14:0] r;
    r = d;
    case (s)
      SOFT_SHIFT4: r = d >> 4;
      SOFT_SHIFT6: r = d >> 6;
      SOFT_SHIFT7: r = d >> 7;
      SOFT_RING:   r = d >> 2;
      default:     r = d;
    endcase
    return r;
  endfunction

endpackage

/* hdl/bzt_if.sv */
// Valid/ready channel interfaces for request and result beats.
interface bzt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  note_slot;
  logic [15:0] note_freq;
  logic [15:0] note_length_ms;
  logic        note_glide;
  logic [2:0]  note_softness;

  modport source (output valid, req_type, note_slot, note_freq, note_length_ms,
                  note_glide, note_softness, input ready);
  modport sink (input valid, req_type, note_slot, note_freq, note_length_ms,
                note_glide, note_softness, output ready);
endinterface

interface bzt_out_if;
  logic        valid;
  logic        ready;
  logic        playing;
  logic        wrap_valid;
  logic [15:0] period_wrap;
  logic [14:0] duty_level;
  logic        stopped_now;

  modport source (output valid, playing, wrap_valid, period_wrap, duty_level,
                  stopped_now, input ready);
  modport sink (input valid, playing, wrap_valid, period_wrap, duty_level,
                stopped_now, output ready);
endinterface

/* hdl/bzt_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module bzt_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bzt_pkg::DIV_W-1:0] dividend,
  input  logic [bzt_pkg::DSR_W-1:0] divisor,
  output logic                      done,
  output logic [bzt_pkg::DIV_W-1:0] quotient,
  output logic [bzt_pkg::DSR_W-1:0] remainder
);
  import bzt_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DSR_W-1:0]  rem_r;
  logic [DSR_W-1:0]  dsr_r;
  logic [DSR_W:0]    rem_sh;
  logic [DSR_W:0]    rem_sub;
  logic              q_bit;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    q_bit   = (rem_sh >= {1'b0, dsr_r});
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Partial remainder and quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], q_bit};
      rem_r <= q_bit ? rem_sub[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* hdl/bzt_dp.sv */
// Datapath: play state, note memory, interpolation multiplier and divider.
module bzt_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  bzt_pkg::cfg_t   cfg,
  input  bzt_pkg::cmd_t   cmd,
  input  logic [1:0]      in_req,
  input  logic [5:0]      in_slot,
  input  logic [15:0]     in_freq,
  input  logic [15:0]     in_len,
  input  logic            in_glide,
  input  logic [2:0]      in_soft,
  output bzt_pkg::sts_t   sts,
  output bzt_pkg::res_t   res
);
  import bzt_pkg::*;

  // Play state.
  logic [31:0]        elapsed_r;
  logic               active_r;
  logic [15:0]        period_r;

  // Latched item and per-item results.
  logic [1:0]         req_r;
  logic [5:0]         slot_r;
  logic [35:0]        wdata_r;
  logic               wv_r;
  logic [14:0]        duty_r;
  logic               stopped_r;
  logic               duty_en_r;

  // Walk and interpolation registers.
  logic [31:0]        t_r;
  logic [NOTE_CW-1:0] idx_r;
  logic [16:0]        c_r;
  logic [15:0]        ia_r;
  logic [15:0]        ib_r;
  logic [15:0]        pos_r;
  logic [15:0]        span_r;
  logic [15:0]        f_r;
  logic [2:0]         soft_r;
  logic signed [33:0] prod_r;
  logic               neg_r;

  // Note memory.
  logic [35:0]        mem [NOTE_DEPTH];
  logic [35:0]        rd_r;

  logic [31:0]        elapsed_inc;
  logic [16:0]        cyc_sum;
  logic [NOTE_CW-1:0] cnt;
  logic [NOTE_CW-1:0] idx_inc;
  logic [15:0]        rd_freq;
  logic [15:0]        rd_len;
  logic               rd_glide;
  logic [2:0]         rd_soft;
  logic signed [16:0] diff;
  logic [33:0]        prod_abs;
  logic [15:0]        quo16;
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [DSR_W-1:0]   div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;
  logic [DSR_W-1:0]   div_rem;
  logic [NOTE_AW-1:0] rd_addr;
  logic               rd_en;
  logic               wr_ok;

  // Derived values.
  always_comb begin
    elapsed_inc = elapsed_r + 32'd1;
    cyc_sum     = {1'b0, cfg.on_time_ms} + {1'b0, cfg.off_time_ms};
    cnt         = (32'(cfg.note_count) < NOTE_DEPTH) ? NOTE_CW'(cfg.note_count)
                                                      : NOTE_CW'(NOTE_DEPTH);
    idx_inc     = idx_r + NOTE_CW'(1);
    rd_freq     = rd_r[35:20];
    rd_len      = rd_r[19:4];
    rd_glide    = rd_r[3];
    rd_soft     = rd_r[2:0];
    diff        = $signed({1'b0, ib_r}) - $signed({1'b0, ia_r});
    prod_abs    = prod_r[33] ? 34'(-prod_r) : 34'(prod_r);
    quo16       = div_quo[15:0];
    wr_ok       = (32'(slot_r) < NOTE_DEPTH);
    rd_addr     = (cmd.op == OP_NOTE_GLIDE) ? idx_inc[NOTE_AW-1:0] : idx_r[NOTE_AW-1:0];
    rd_en       = (cmd.op == OP_NOTE_RD) || (cmd.op == OP_NOTE_GLIDE);
  end

  // Divider operand selection.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = elapsed_r;
    div_divisor  = cyc_sum;
    unique case (cmd.op)
      OP_CPOS_GO: div_start = (cyc_sum != '0);
      OP_IDIV_GO: begin
        div_start    = 1'b1;
        div_dividend = prod_abs[31:0];
        div_divisor  = {1'b0, span_r};
      end
      OP_WDIV_GO: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(TICKS_PER_SECOND_SCALE);
        div_divisor  = {1'b0, f_r};
      end
      default: div_start = 1'b0;
    endcase
  end

  bzt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Note memory write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_WRITE && wr_ok) begin
      mem[NOTE_AW'(slot_r)] <= wdata_r;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Play state, reset to silence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      active_r  <= 1'b0;
      period_r  <= PERIOD_RESET;
    end else begin
      unique case (cmd.op)
        OP_START: begin
          elapsed_r <= '0;
          active_r  <= (cfg.total_duration_ms != '0);
        end
        OP_TICK: begin
          elapsed_r <= elapsed_inc;
          if (sts.tick_stop) begin
            active_r <= 1'b0;
          end
        end
        OP_MEL_STOP:  active_r <= 1'b0;
        OP_WRAP_ZERO: period_r <= '0;
        OP_WDIV_GET:  period_r <= quo16;
        default:      active_r <= active_r;
      endcase
    end
  end

  // Item registers and working values.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        req_r     <= in_req;
        slot_r    <= in_slot;
        wdata_r   <= {in_freq, in_len, in_glide, in_soft};
        wv_r      <= 1'b0;
        duty_r    <= '0;
        stopped_r <= 1'b0;
        duty_en_r <= 1'b0;
        soft_r    <= SOFT_NONE;
      end
      OP_START: f_r <= cfg.tone_frequency;
      OP_TICK: begin
        t_r       <= elapsed_inc;
        idx_r     <= '0;
        duty_en_r <= 1'b1;
        stopped_r <= sts.tick_stop;
      end
      OP_CPOS_GO:   c_r <= '0;
      OP_CPOS_GET:  c_r <= div_rem;
      OP_TONE_DUTY: duty_r <= period_r[15:1];
      OP_SWEEP_SET: begin
        ia_r   <= cfg.sweep_start_freq;
        ib_r   <= cfg.sweep_end_freq;
        pos_r  <= c_r[15:0];
        span_r <= cfg.on_time_ms;
      end
      OP_MUL:       prod_r <= diff * $signed({1'b0, pos_r});
      OP_F_START:   f_r <= ia_r;
      OP_IDIV_GO:   neg_r <= prod_r[33];
      OP_IDIV_GET:  f_r <= neg_r ? (ia_r - quo16) : (ia_r + quo16);
      OP_WRAP_ZERO: begin
        wv_r   <= 1'b1;
        duty_r <= '0;
      end
      OP_WDIV_GET: begin
        wv_r   <= 1'b1;
        duty_r <= duty_en_r ? soft_shift(quo16[15:1], soft_r) : 15'd0;
      end
      OP_MEL_STOP:  stopped_r <= 1'b1;
      OP_NOTE_SKIP: begin
        t_r   <= t_r - 32'(rd_len);
        idx_r <= idx_inc;
      end
      OP_NOTE_GLIDE: begin
        ia_r   <= rd_freq;
        pos_r  <= t_r[15:0];
        span_r <= rd_len;
        soft_r <= rd_soft;
      end
      OP_NOTE_PLAY: begin
        f_r    <= rd_freq;
        soft_r <= rd_soft;
      end
      OP_NEXT_GET:  ib_r <= rd_freq;
      default:      neg_r <= neg_r;
    endcase
  end

  // Status toward the controller.
  always_comb begin
    sts.req           = req_r;
    sts.mode          = cfg.sound_mode;
    sts.active        = active_r;
    sts.start_blocked = (cfg.sound_mode == MODE_TONE || cfg.sound_mode == MODE_SWEEP)
                        && (cfg.on_time_ms == '0);
    sts.tick_stop     = (cfg.total_duration_ms != DUR_ENDLESS)
                        && (elapsed_inc > 32'(cfg.total_duration_ms));
    sts.sum_zero      = (cyc_sum == '0);
    sts.c_le_on       = (c_r <= {1'b0, cfg.on_time_ms});
    sts.idx_ge_cnt    = (idx_r >= cnt);
    sts.t_gt_len      = (t_r > 32'(rd_len));
    sts.nf_zero       = (rd_freq == '0);
    sts.glide_ok      = rd_glide && (idx_inc < cnt);
    sts.span_zero     = (span_r == '0);
    sts.f_zero        = (f_r == '0);
    sts.div_done      = div_done;
  end

  // Result of the item.
  always_comb begin
    res.playing     = active_r;
    res.wrap_valid  = wv_r;
    res.period_wrap = period_r;
    res.duty_level  = duty_r;
    res.stopped_now = stopped_r;
  end

endmodule

/* hdl/bzt_ctrl.sv */
// Controller state machine sequencing the datapath for one item at a time.
module bzt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_free,
  input  bzt_pkg::sts_t sts,
  output logic          in_ready,
  output bzt_pkg::cmd_t cmd
);
  import bzt_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_DECODE   = 14'b00000000000010,
    ST_CPOS     = 14'b00000000000100,
    ST_CWAIT    = 14'b00000000001000,
    ST_POS      = 14'b00000000010000,
    ST_NOTE_RD  = 14'b00000000100000,
    ST_NOTE_CHK = 14'b00000001000000,
    ST_NEXT     = 14'b00000010000000,
    ST_MUL      = 14'b00000100000000,
    ST_IDIV     = 14'b00001000000000,
    ST_IWAIT    = 14'b00010000000000,
    ST_WRAP     = 14'b00100000000000,
    ST_WWAIT    = 14'b01000000000000,
    ST_DONE     = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NOP;
    cmd.out_load = 1'b0;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_DONE;
        priority if (sts.req == REQ_WRITE) begin
          cmd.op = OP_WRITE;
        end else if (sts.req == REQ_START) begin
          if (!sts.start_blocked) begin
            cmd.op = OP_START;
            if (sts.mode == MODE_TONE) begin
              state_nxt = ST_WRAP;
            end
          end
        end else if (sts.req == REQ_TICK && sts.active) begin
          cmd.op = OP_TICK;
          priority if (sts.tick_stop) begin
            state_nxt = ST_DONE;
          end else if (sts.mode == MODE_TONE || sts.mode == MODE_SWEEP) begin
            state_nxt = ST_CPOS;
          end else if (sts.mode == MODE_MELODY) begin
            state_nxt = ST_NOTE_RD;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_CPOS: begin
        cmd.op    = OP_CPOS_GO;
        state_nxt = sts.sum_zero ? ST_POS : ST_CWAIT;
      end
      ST_CWAIT: begin
        if (sts.div_done) begin
          cmd.op    = OP_CPOS_GET;
          state_nxt = ST_POS;
        end
      end
      ST_POS: begin
        state_nxt = ST_DONE;
        if (sts.c_le_on) begin
          if (sts.mode == MODE_TONE) begin
            cmd.op = OP_TONE_DUTY;
          end else begin
            cmd.op    = OP_SWEEP_SET;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_NOTE_RD: begin
        if (sts.idx_ge_cnt) begin
          cmd.op    = OP_MEL_STOP;
          state_nxt = ST_DONE;
        end else begin
          cmd.op    = OP_NOTE_RD;
          state_nxt = ST_NOTE_CHK;
        end
      end
      ST_NOTE_CHK: begin
        priority if (sts.t_gt_len) begin
          cmd.op    = OP_NOTE_SKIP;
          state_nxt = ST_NOTE_RD;
        end else if (sts.nf_zero) begin
          state_nxt = ST_DONE;
        end else if (sts.glide_ok) begin
          cmd.op    = OP_NOTE_GLIDE;
          state_nxt = ST_NEXT;
        end else begin
          cmd.op    = OP_NOTE_PLAY;
          state_nxt = ST_WRAP;
        end
      end
      ST_NEXT: begin
        cmd.op    = OP_NEXT_GET;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = ST_IDIV;
      end
      ST_IDIV: begin
        if (sts.span_zero) begin
          cmd.op    = OP_F_START;
          state_nxt = ST_WRAP;
        end else begin
          cmd.op    = OP_IDIV_GO;
          state_nxt = ST_IWAIT;
        end
      end
      ST_IWAIT: begin
        if (sts.div_done) begin
          cmd.op    = OP_IDIV_GET;
          state_nxt = ST_WRAP;
        end
      end
      ST_WRAP: begin
        if (sts.f_zero) begin
          cmd.op    = OP_WRAP_ZERO;
          state_nxt = ST_DONE;
        end else begin
          cmd.op    = OP_WDIV_GO;
          state_nxt = ST_WWAIT;
        end
      end
      ST_WWAIT: begin
        if (sts.div_done) begin
          cmd.op    = OP_WDIV_GET;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* hdl/buzzer_tone_sweep_melody_player.sv */
// Top level of the buzzer player: register port, controller, datapath, result register.
//
//   channel   direction  handshake                  beat contents
//   in_ch     in         valid/ready                request, note slot and note fields
//   out_ch    out        valid/ready                playing, wrap, level, stop flag
//   cfg_*     in         APB write/read, pready=1   eight mode and timing registers
//
// One beat at a time: a request is taken only in the idle state. Writes, non-tone starts and
// idle or stopping ticks end after decode; a tone start divides for the wrap, a tone tick for
// its place in the on/off period, and a sweep tick may also interpolate and divide for the wrap.
// A melody tick reads notes in turn, a glide also interpolates; each division waits on the divider.
// Reset (rst_n low at a clock edge) clears play state; the note memory is not cleared.
// A waiting result beat holds the next finished beat in the controller, stalling input.
module buzzer_tone_sweep_melody_player (
  input  logic        clk,
  input  logic        rst_n,
  bzt_in_if.sink      in_ch,
  bzt_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bzt_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  res_t res;
  res_t out_res_r;
  logic out_valid_r;
  logic in_ready;
  logic out_free;
  logic cfg_wr;
  logic [2:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[4:2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sound_mode        <= MODE_TONE;
      cfg_r.tone_frequency    <= TONE_RESET;
      cfg_r.sweep_start_freq  <= '0;
      cfg_r.sweep_end_freq    <= '0;
      cfg_r.on_time_ms        <= '0;
      cfg_r.off_time_ms       <= '0;
      cfg_r.total_duration_ms <= '0;
      cfg_r.note_count        <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:     cfg_r.sound_mode        <= cfg_pwdata[1:0];
        REG_TONE:     cfg_r.tone_frequency    <= cfg_pwdata[15:0];
        REG_SW_START: cfg_r.sweep_start_freq  <= cfg_pwdata[15:0];
        REG_SW_END:   cfg_r.sweep_end_freq    <= cfg_pwdata[15:0];
        REG_ON:       cfg_r.on_time_ms        <= cfg_pwdata[15:0];
        REG_OFF:      cfg_r.off_time_ms       <= cfg_pwdata[15:0];
        REG_DUR:      cfg_r.total_duration_ms <= cfg_pwdata[15:0];
        REG_COUNT:    cfg_r.note_count        <= cfg_pwdata[6:0];
        default:      cfg_r.note_count        <= cfg_r.note_count;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (cfg_idx)
      REG_MODE:     cfg_prdata = 32'(cfg_r.sound_mode);
      REG_TONE:     cfg_prdata = 32'(cfg_r.tone_frequency);
      REG_SW_START: cfg_prdata = 32'(cfg_r.sweep_start_freq);
      REG_SW_END:   cfg_prdata = 32'(cfg_r.sweep_end_freq);
      REG_ON:       cfg_prdata = 32'(cfg_r.on_time_ms);
      REG_OFF:      cfg_prdata = 32'(cfg_r.off_time_ms);
      REG_DUR:      cfg_prdata = 32'(cfg_r.total_duration_ms);
      REG_COUNT:    cfg_prdata = 32'(cfg_r.note_count);
      default:      cfg_prdata = '0;
    endcase
  end

  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;

  bzt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  bzt_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd      (cmd),
    .in_req   (in_ch.req_type),
    .in_slot  (in_ch.note_slot),
    .in_freq  (in_ch.note_freq),
    .in_len   (in_ch.note_length_ms),
    .in_glide (in_ch.note_glide),
    .in_soft  (in_ch.note_softness),
    .sts      (sts),
    .res      (res)
  );

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.playing     = out_res_r.playing;
  assign out_ch.wrap_valid  = out_res_r.wrap_valid;
  assign out_ch.period_wrap = out_res_r.period_wrap;
  assign out_ch.duty_level  = out_res_r.duty_level;
  assign out_ch.stopped_now = out_res_r.stopped_now;

endmodule

/* hdl/bzt_chk.sv */
// Port-level checker of the buzzer player and its bind to the top level.
`include "buzzer_tone_sweep_melody_player_defines.svh"

module bzt_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        playing,
  input logic        wrap_valid,
  input logic [15:0] period_wrap,
  input logic [14:0] duty_level,
  input logic        stopped_now
);

  // A stalled result beat keeps its contents.
  `BZT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(period_wrap) && $stable(duty_level) && $stable(playing))

  // A beat that ends play shows silence and no new period.
  `BZT_ASSERT_IMP(a_stop_silent, clk, rst_n, out_valid && stopped_now, !playing && !wrap_valid && duty_level == 15'd0)

  // A sounding level only comes while play continues.
  `BZT_ASSERT_IMP(a_duty_playing, clk, rst_n, out_valid && duty_level != 15'd0, playing)

  // The level never exceeds half the period.
  `BZT_ASSERT_IMP(a_duty_half, clk, rst_n, out_valid, duty_level <= period_wrap[15:1])

endmodule

bind buzzer_tone_sweep_melody_player bzt_chk u_bzt_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .playing     (out_ch.playing),
  .wrap_valid  (out_ch.wrap_valid),
  .period_wrap (out_ch.period_wrap),
  .duty_level  (out_ch.duty_level),
  .stopped_now (out_ch.stopped_now)
);

/* verif/buzzer_tone_sweep_melody_player_checker.sv */
// Checker for the buzzer player: tracks registers, predicts each result beat and compares.
`timescale 1ns / 1ps

module buzzer_tone_sweep_melody_player_checker (
  input  logic        clk,
  input  logic        rst_n,
  bzt_in_if           in_ch,
  bzt_out_if          out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending
);
  import bzt_pkg::*;

  // Shadow copy of the registers and of the play state.
  cfg_t        regs;
  logic [31:0] elapsed;
  logic        sounding;
  logic [15:0] period;
  logic [15:0] note_hz  [NOTE_DEPTH];
  logic [15:0] note_len [NOTE_DEPTH];
  logic        note_gl  [NOTE_DEPTH];
  logic [2:0]  note_sf  [NOTE_DEPTH];
  res_t        expected_q[$];

  initial fail_count = 0;
  initial pending = 0;

  function automatic logic [15:0] period_of(input longint f);
    longint q;
    if (f == 0) return 16'd0;
    q = longint'(TICKS_PER_SECOND_SCALE) / f;
    return q[15:0];
  endfunction

  // Linear interpolation, truncating toward zero.
  function automatic longint lerp(input longint s, input longint e, input longint p,
                                  input longint span);
    if (span == 0) return s;
    return s + ((e - s) * p) / span;
  endfunction

  function automatic logic [31:0] cycle_pos();
    logic [31:0] sum;
    sum = 32'(regs.on_time_ms) + 32'(regs.off_time_ms);
    return (sum != 0) ? elapsed % sum : 32'd0;
  endfunction

  // Advances the shadow state by one request beat and returns the result beat.
  function automatic res_t play_step(input logic [1:0] req, input logic [5:0] slot,
                                     input logic [15:0] hz, input logic [15:0] len,
                                     input logic gl, input logic [2:0] sf);
    res_t r;
    logic [31:0] c, t, cnt, idx;
    logic [15:0] duty;
    r = '0;
    duty = '0;
    if (req == REQ_WRITE) begin
      note_hz[slot] = hz;
      note_len[slot] = len;
      note_gl[slot] = gl;
      note_sf[slot] = sf;
    end else if (req == REQ_START) begin
      if (!(regs.sound_mode <= MODE_SWEEP && regs.on_time_ms == 0)) begin
        elapsed = 0;
        sounding = (regs.total_duration_ms != 0);
        if (regs.sound_mode == MODE_TONE) begin
          period = period_of(regs.tone_frequency);
          r.wrap_valid = 1'b1;
        end
      end
    end else if (req == REQ_TICK && sounding) begin
      elapsed = elapsed + 1;
      if (regs.total_duration_ms != DUR_ENDLESS && elapsed > 32'(regs.total_duration_ms)) begin
        sounding = 1'b0;
        r.stopped_now = 1'b1;
      end else if (regs.sound_mode == MODE_SWEEP) begin
        c = cycle_pos();
        if (c <= 32'(regs.on_time_ms)) begin
          period = period_of(lerp(regs.sweep_start_freq, regs.sweep_end_freq, c,
                                  regs.on_time_ms));
          r.wrap_valid = 1'b1;
          duty = period >> 1;
        end
      end else if (regs.sound_mode == MODE_MELODY) begin
        cnt = (regs.note_count < NOTE_DEPTH) ? 32'(regs.note_count) : NOTE_DEPTH;
        t = elapsed;
        idx = 0;
        while (idx < cnt && t > 32'(note_len[idx])) begin
          t = t - note_len[idx];
          idx++;
        end
        if (idx >= cnt) begin
          sounding = 1'b0;
          r.stopped_now = 1'b1;
        end else if (note_hz[idx] != 0) begin
          if (note_gl[idx] && idx + 1 < cnt)
            period = period_of(lerp(note_hz[idx], note_hz[idx + 1], t, note_len[idx]));
          else
            period = period_of(note_hz[idx]);
          r.wrap_valid = 1'b1;
          duty = period >> 1;
          case (note_sf[idx])
            SOFT_SHIFT4: duty = duty >> 4;
            SOFT_SHIFT6: duty = duty >> 6;
            SOFT_SHIFT7: duty = duty >> 7;
            SOFT_RING:   duty = duty >> 2;
            default:     duty = duty;
          endcase
        end
      end else if (regs.sound_mode == MODE_TONE) begin
        if (cycle_pos() <= 32'(regs.on_time_ms)) duty = period >> 1;
      end
    end
    r.playing = sounding;
    r.period_wrap = period;
    r.duty_level = duty[14:0];
    return r;
  endfunction

  // Watch both channels and the register port at each rising edge.
  always @(posedge clk) begin
    res_t want, got;
    if (!rst_n) begin
      regs = '0;
      regs.tone_frequency = TONE_RESET;
      elapsed = 0;
      sounding = 1'b0;
      period = PERIOD_RESET;
      expected_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_MODE:     regs.sound_mode = cfg_pwdata[1:0];
          REG_TONE:     regs.tone_frequency = cfg_pwdata[15:0];
          REG_SW_START: regs.sweep_start_freq = cfg_pwdata[15:0];
          REG_SW_END:   regs.sweep_end_freq = cfg_pwdata[15:0];
          REG_ON:       regs.on_time_ms = cfg_pwdata[15:0];
          REG_OFF:      regs.off_time_ms = cfg_pwdata[15:0];
          REG_DUR:      regs.total_duration_ms = cfg_pwdata[15:0];
          REG_COUNT:    regs.note_count = cfg_pwdata[6:0];
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(play_step(in_ch.req_type, in_ch.note_slot, in_ch.note_freq,
                                       in_ch.note_length_ms, in_ch.note_glide,
                                       in_ch.note_softness));
      if (out_ch.valid && out_ch.ready) begin
        got.playing = out_ch.playing;
        got.wrap_valid = out_ch.wrap_valid;
        got.period_wrap = out_ch.period_wrap;
        got.duty_level = out_ch.duty_level;
        got.stopped_now = out_ch.stopped_now;
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: %p", $time, got);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            $display("%0t: result mismatch: expected %p, actual %p", $time, want, got);
            fail_count++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

/* verif/buzzer_tone_sweep_melody_player_test.sv */
// Testbench top for the buzzer player: clock, reset, register writes, request and result traffic.
`timescale 1ns / 1ps

module buzzer_tone_sweep_melody_player_test;
  import bzt_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int ITEM_TARGET = 1250;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending;
  int          items_sent;
  int          quiet_cycles;
  bit          hold_out;
  bit          steady_in;

  bzt_in_if  in_ch ();
  bzt_out_if out_ch ();

  buzzer_tone_sweep_melody_player i_dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  buzzer_tone_sweep_melody_player_checker i_checker (
    .clk, .rst_n, .in_ch, .out_ch, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready,
    .cfg_paddr, .cfg_pwdata, .fail_count, .pending
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Cycles with no beat moving on either channel end the run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Result side: random stalls, calm stretches, and one long hold-off on request.
  initial begin
    bit calm;
    int n;
    out_ch.ready <= 1'b0;
    calm = 0;
    n = 0;
    @(posedge clk);
    forever begin
      if (hold_out) begin
        hold_out = 0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 9) < 3) begin
        out_ch.ready <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 80)) @(posedge clk);
        else repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
      if (++n >= 200) begin
        n = 0;
        calm = ($urandom_range(0, 3) == 0);
      end
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Sends one request beat and waits for it to be taken, then maybe idles.
  task automatic send_beat(input logic [1:0] req, input logic [5:0] slot,
                           input logic [15:0] hz, input logic [15:0] len,
                           input logic gl, input logic [2:0] sf);
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.note_slot <= slot;
    in_ch.note_freq <= hz;
    in_ch.note_length_ms <= len;
    in_ch.note_glide <= gl;
    in_ch.note_softness <= sf;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (!steady_in && $urandom_range(0, 9) < 3) begin
      in_ch.valid <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic write_note(input logic [5:0] slot, input bit short_len);
    send_beat(REQ_WRITE, slot, $urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom),
              short_len ? 16'($urandom_range(0, 12)) : 16'($urandom), 1'($urandom),
              3'($urandom));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One play phase: registers set while idle, then a start and a run of mostly ticks.
  task automatic play_phase(input logic [1:0] mode, input logic [15:0] tone_hz,
                            input logic [15:0] sw_from, input logic [15:0] sw_to,
                            input logic [15:0] on_ms, input logic [15:0] off_ms,
                            input logic [15:0] dur_ms, input logic [6:0] count,
                            input int ticks);
    int k;
    drain();
    reg_write(REG_MODE, 32'(mode));
    reg_write(REG_TONE, 32'(tone_hz));
    reg_write(REG_SW_START, 32'(sw_from));
    reg_write(REG_SW_END, 32'(sw_to));
    reg_write(REG_ON, 32'(on_ms));
    reg_write(REG_OFF, 32'(off_ms));
    reg_write(REG_DUR, 32'(dur_ms));
    reg_write(REG_COUNT, 32'(count));
    steady_in = ($urandom_range(0, 3) == 0);
    send_beat(REQ_START, 6'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
              3'($urandom));
    for (k = 0; k < ticks; k++) begin
      case ($urandom_range(0, 39))
        0, 1:    write_note(6'($urandom), 1'($urandom_range(0, 3) != 0));
        2:       send_beat(REQ_START, 6'($urandom), 16'($urandom), 16'($urandom),
                           1'($urandom), 3'($urandom));
        default: send_beat(REQ_TICK, 6'($urandom), 16'($urandom), 16'($urandom),
                           1'($urandom), 3'($urandom));
      endcase
    end
  endtask

  function automatic logic [15:0] pick_hz();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(15, 17));
      default: return 16'($urandom_range(100, 8000));
    endcase
  endfunction

  function automatic logic [15:0] pick_ms();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 25));
    endcase
  endfunction

  // Main stimulus.
  initial begin
    int s;
    logic [15:0] dur;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= REQ_TICK;
    in_ch.note_slot <= '0;
    in_ch.note_freq <= '0;
    in_ch.note_length_ms <= '0;
    in_ch.note_glide <= 1'b0;
    in_ch.note_softness <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    hold_out = 0;
    steady_in = 0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole note memory so no walk ever reads an unwritten entry.
    for (s = 0; s < NOTE_DEPTH; s++) write_note(6'(s), 1'b1);

    // Directed: blocked start, zero duration, tone extremes, sweep extremes,
    // glide on the last note, empty melody, oversize note count, unknown mode.
    play_phase(MODE_TONE, 16'd1000, 0, 0, 16'd0, 16'd5, 16'd10, 0, 3);
    play_phase(MODE_TONE, 16'd1000, 0, 0, 16'd3, 16'd0, 16'd0, 0, 2);
    play_phase(MODE_TONE, 16'hFFFF, 0, 0, 16'd2, 16'd2, 16'd6, 0, 8);
    play_phase(MODE_TONE, 16'd0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 3);
    play_phase(MODE_SWEEP, 16'd1, 16'd0, 16'hFFFF, 16'd4, 16'd0, 16'd6, 0, 7);
    play_phase(MODE_SWEEP, 16'hFFFF, 16'hFFFF, 16'd1, 16'd3, 16'd2, 16'hFFFF, 0, 6);
    send_beat(REQ_WRITE, 6'd0, 16'd440, 16'd3, 1'b1, SOFT_SHIFT4);
    send_beat(REQ_WRITE, 6'd1, 16'd880, 16'd3, 1'b1, SOFT_RING);
    play_phase(MODE_MELODY, 0, 0, 0, 16'd0, 16'd0, 16'hFFFF, 7'd2, 8);
    play_phase(MODE_MELODY, 0, 0, 0, 16'd0, 16'd0, 16'd5, 7'd0, 2);
    play_phase(2'd3, 0, 0, 0, 16'd1, 16'd1, 16'd3, 7'h7F, 5);

    // Long receiver hold-off while requests keep coming.
    hold_out = 1;
    play_phase(MODE_MELODY, 0, 0, 0, 16'd1, 16'd1, 16'hFFFF, 7'h7F, 30);

    // Random phases, mostly start-then-ticks with random content.
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        for (s = 0; s < 8; s++) write_note(6'($urandom), 1'b1);
      end
      case ($urandom_range(0, 3))
        0: dur = 16'd0;
        1: dur = 16'hFFFF;
        default: dur = 16'($urandom_range(1, 80));
      endcase
      play_phase(2'($urandom), pick_hz(), pick_hz(), pick_hz(), pick_ms(), pick_ms(), dur,
                 ($urandom_range(0, 5) == 0) ? 7'($urandom) : 7'($urandom_range(0, 12)),
                 $urandom_range(10, 60));
    end

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
